@@ design/fcf_pkg.sv @@
// ----------------------------------------------------------------------------
// Four-channel CRC-16 framer package
// Shared widths, frame constants, the frame record passed from the CRC
// pipeline to the serializer, and the byte-wide CRC-16/MODBUS update.
// ----------------------------------------------------------------------------
package fcf_pkg;

  localparam int CHAN_W      = 16;
  localparam int NUM_CHAN    = 4;
  localparam int BYTE_W      = 8;
  localparam int DATA_BYTES  = NUM_CHAN * CHAN_W / BYTE_W;
  localparam int DATA_W      = DATA_BYTES * BYTE_W;
  localparam int CRC_W       = 16;
  localparam int FRAME_BYTES = DATA_BYTES + CRC_W / BYTE_W;
  localparam int FRAME_W     = FRAME_BYTES * BYTE_W;
  localparam int CNT_W       = $clog2(FRAME_BYTES);

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

  localparam logic [CNT_W-1:0] LAST_BYTE = CNT_W'(FRAME_BYTES - 1);

  // A frame leaving the CRC pipeline: data bytes, low byte of channel 0 in
  // the low bits, and the finished CRC.
  typedef struct packed {
    logic [CRC_W-1:0]  crc;
    logic [DATA_W-1:0] data;
  } frame_t;

  // Reflected CRC-16 update over one byte, one bit per step.
  function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data_byte);
    logic [CRC_W-1:0] crc;
    crc = crc_in ^ {{(CRC_W - BYTE_W){1'b0}}, data_byte};
    for (int b = 0; b < BYTE_W; b++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

@@ design/fcf_in_if.sv @@
// ----------------------------------------------------------------------------
// Sample channel interface
// Valid/ready channel carrying the four 16-bit channel values of one frame.
// ----------------------------------------------------------------------------
interface fcf_in_if;
  logic                      valid;
  logic                      ready;
  logic [fcf_pkg::CHAN_W-1:0] channel_0;
  logic [fcf_pkg::CHAN_W-1:0] channel_1;
  logic [fcf_pkg::CHAN_W-1:0] channel_2;
  logic [fcf_pkg::CHAN_W-1:0] channel_3;

  modport source (output valid, output channel_0, output channel_1,
                  output channel_2, output channel_3, input ready);
  modport sink   (input valid, input channel_0, input channel_1,
                  input channel_2, input channel_3, output ready);
endinterface

@@ design/fcf_out_if.sv @@
// ----------------------------------------------------------------------------
// Frame byte interface
// Valid/ready channel carrying one frame byte and its end-of-frame flag.
// ----------------------------------------------------------------------------
interface fcf_out_if;
  logic                      valid;
  logic                      ready;
  logic [fcf_pkg::BYTE_W-1:0] frame_byte;
  logic                      frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

@@ design/fcf_crc_pipe.sv @@
// ----------------------------------------------------------------------------
// CRC pipeline
// One register stage per data byte. Each stage folds one byte into the
// running CRC; a stage advances whenever it is empty or its successor moves.
// ----------------------------------------------------------------------------
module fcf_crc_pipe (
  input  logic            clk,
  input  logic            rst,
  fcf_in_if.sink          samples,
  output logic            frame_valid,
  input  logic            frame_ready,
  output fcf_pkg::frame_t frame
);

  localparam int N = fcf_pkg::DATA_BYTES;

  logic [N-1:0]                stage_valid;
  logic [N-1:0]                stage_ready;
  logic [fcf_pkg::DATA_W-1:0]  stage_data [N];
  logic [fcf_pkg::CRC_W-1:0]   stage_crc  [N];

  logic [N-1:0]                src_valid;
  logic [fcf_pkg::DATA_W-1:0]  src_data [N];
  logic [fcf_pkg::CRC_W-1:0]   src_crc  [N];

  // The first stage takes the channels, low byte of channel 0 first.
  assign src_valid[0] = samples.valid;
  assign src_data[0]  = {samples.channel_3, samples.channel_2,
                         samples.channel_1, samples.channel_0};
  assign src_crc[0]   = fcf_pkg::CRC_INIT;
  assign samples.ready = stage_ready[0];

  for (genvar k = 0; k < N; k++) begin : g_stage
    // Hand-off to the next stage, or to the serializer after the last one.
    if (k < N - 1) begin : g_link
      assign src_valid[k+1] = stage_valid[k];
      assign src_data[k+1]  = stage_data[k];
      assign src_crc[k+1]   = stage_crc[k];
      assign stage_ready[k] = !stage_valid[k] || stage_ready[k+1];
    end else begin : g_tail
      assign stage_ready[k] = !stage_valid[k] || frame_ready;
    end

    // Valid bit of this stage.
    always_ff @(posedge clk) begin
      if (rst) begin
        stage_valid[k] <= 1'b0;
      end else if (stage_ready[k]) begin
        stage_valid[k] <= src_valid[k];
      end
    end

    // Payload: carry the data and fold in byte k.
    always_ff @(posedge clk) begin
      if (stage_ready[k] && src_valid[k]) begin
        stage_data[k] <= src_data[k];
        stage_crc[k]  <= fcf_pkg::crc_update(src_crc[k],
                                             src_data[k][k*fcf_pkg::BYTE_W +: fcf_pkg::BYTE_W]);
      end
    end
  end

  assign frame_valid = stage_valid[N-1];
  assign frame.data  = stage_data[N-1];
  assign frame.crc   = stage_crc[N-1];

endmodule

@@ design/fcf_serializer.sv @@
// ----------------------------------------------------------------------------
// Frame serializer
// Loads a finished frame into a shift register and sends it one byte per
// transfer, raising the end flag on the last byte.
// ----------------------------------------------------------------------------
module fcf_serializer (
  input  logic            clk,
  input  logic            rst,
  input  logic            frame_valid,
  output logic            frame_ready,
  input  fcf_pkg::frame_t frame,
  fcf_out_if.source       bytes
);

  logic                        busy;
  logic [fcf_pkg::CNT_W-1:0]   count;
  logic [fcf_pkg::FRAME_W-1:0] shift;
  logic                        out_fire;
  logic                        last_fire;

  assign out_fire  = busy && bytes.ready;
  assign last_fire = out_fire && (count == fcf_pkg::LAST_BYTE);

  // A new frame loads when idle or as the last byte of the current one leaves.
  assign frame_ready = !busy || last_fire;

  // Control: busy flag and byte counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (frame_ready && frame_valid) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (last_fire) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (out_fire) begin
      count <= count + 1'b1;
    end
  end

  // Payload shift register; the low byte is the byte on offer.
  always_ff @(posedge clk) begin
    if (frame_ready && frame_valid) begin
      shift <= {frame.crc, frame.data};
    end else if (out_fire) begin
      shift <= shift >> fcf_pkg::BYTE_W;
    end
  end

  assign bytes.valid      = busy;
  assign bytes.frame_byte = shift[fcf_pkg::BYTE_W-1:0];
  assign bytes.frame_end  = (count == fcf_pkg::LAST_BYTE);

endmodule

@@ design/four_channel_crc16_framer_core.sv @@
// ----------------------------------------------------------------------------
// Four-channel CRC-16 framer
// A frame's samples pass through the eight CRC stages and are loaded into the
// serializer's shift register before its first byte is offered; the ten bytes
// then follow one per cycle while the output port is ready.
// The one-byte output port limits the frame rate; the eight-stage CRC pipeline
// accepts samples every cycle until it fills.
// Reset: synchronous, clears all valid bits and the byte counter.
// ----------------------------------------------------------------------------
module four_channel_crc16_framer_core (
  input  logic      clk,
  input  logic      rst,
  fcf_in_if.sink    samples,
  fcf_out_if.source bytes
);

  logic            frame_valid;
  logic            frame_ready;
  fcf_pkg::frame_t frame;

  // CRC over the eight data bytes, one byte per stage.
  fcf_crc_pipe u_crc_pipe (
    .clk         (clk),
    .rst         (rst),
    .samples     (samples),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame)
  );

  // Byte-wide output of data and CRC.
  fcf_serializer u_serializer (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame),
    .bytes       (bytes)
  );

endmodule
